/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the scanner modules.
// Every macro samples on the rising edge of clk and is quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define JTS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the first condition holds, the second must hold at the same edge.
`define JTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/jts_pkg.sv */
// ----------------------------------------------------------------------------
// jts_pkg
// Types and constants shared by the JSON token scanner modules.
// ----------------------------------------------------------------------------
package jts_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_DEPTH_DEF   = 255;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // One input byte causes at most this many result items.
  localparam int unsigned MAX_RES = 3;

  // Result kinds.
  typedef enum logic [3:0] {
    K_BEGIN_OBJ = 4'd0,
    K_END_OBJ   = 4'd1,
    K_BEGIN_ARR = 4'd2,
    K_END_ARR   = 4'd3,
    K_STR_BYTE  = 4'd4,
    K_STR_END   = 4'd5,
    K_KEY_END   = 4'd6,
    K_NUM_BYTE  = 4'd7,
    K_NUM_END   = 4'd8,
    K_ERROR     = 4'd9,
    K_DOC_END   = 4'd10
  } kind_t;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    E_NONE     = 2'd0,
    E_BAD_BYTE = 2'd1,
    E_BAD_HEX  = 2'd2,
    E_DEPTH    = 2'd3
  } err_t;

  // One result item, without its last flag.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  nesting;
    err_t        err;
  } item_t;

  // All results caused by one input byte; cnt is 1 to 3 in the queue.
  typedef struct packed {
    logic [1:0]              cnt;
    item_t [MAX_RES-1:0]     items;
  } bundle_t;

  function automatic item_t mk_item(kind_t k, logic [7:0] d, logic [7:0] n, err_t e);
    item_t it;
    it.kind    = k;
    it.data    = d;
    it.nesting = n;
    it.err     = e;
    return it;
  endfunction

endpackage

/* sv/json_token_scanner.sv */
// A result passes from the front end through the bundle queue into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with k results
// takes k output transfers, and the bundle queue absorbs those bursts until it fills.
// Reset (rst_n low, synchronous) returns to scanning between tokens at depth zero
// and empties the queue; restart on a byte does the same for the scan state only.
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON tokenizer: one text byte in per transaction, structural tokens,
// string bytes and number bytes out, with nesting depth and sticky errors.
// ----------------------------------------------------------------------------
module json_token_scanner #(
  parameter int unsigned MAX_DEPTH   = jts_pkg::MAX_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] data_byte, [15:8] nesting, [17:16] error_code
  output logic [3:0]  out_tuser,  // [3:0] kind
  output logic        out_tlast
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             q_not_full;
  logic             q_not_empty;
  jts_pkg::bundle_t front_bundle;
  jts_pkg::bundle_t head_bundle;
  jts_pkg::item_t   out_item;

  assign in_tready = q_not_full;
  assign accept    = in_tvalid && q_not_full;

  // Front end: scan state and classification.
  jts_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_tdata),
    .restart   (in_tuser),
    .push      (push),
    .bundle    (front_bundle)
  );

  // Bundle queue.
  jts_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (front_bundle),
    .pop       (pop),
    .dout      (head_bundle),
    .not_full  (q_not_full),
    .not_empty (q_not_empty)
  );

  // Output side.
  jts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_bundle),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, out_item.err, out_item.nesting, out_item.data};
  assign out_tuser = out_item.kind;

endmodule

/* sv/jts_front.sv */
// ----------------------------------------------------------------------------
// jts_front
// Scanner front end: classifies each accepted byte against the scan state
// and produces the bundle of result items that the byte causes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jts_front #(
  parameter int unsigned MAX_DEPTH = jts_pkg::MAX_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  input  logic             restart,
  output logic             push,
  output jts_pkg::bundle_t bundle
);

  localparam logic [7:0] LIMIT = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_ESC = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [2:0] {
    M_IDLE, M_STR, M_ESC, M_HEX, M_AFTER, M_NUM, M_DONE, M_ERR
  } mode_t;

  // Outcome of a byte seen between tokens.
  typedef struct packed {
    logic [1:0]      cnt;
    jts_pkg::item_t  a;
    jts_pkg::item_t  b;
    mode_t           mode;
    logic [7:0]      depth;
    jts_pkg::err_t   err;
  } idle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Handling of a byte between tokens at the given depth.
  function automatic idle_t run_idle(logic [7:0] c, logic [7:0] d);
    idle_t       r;
    logic [7:0]  nd;
    r.cnt   = 2'd0;
    r.a     = '0;
    r.b     = '0;
    r.mode  = M_IDLE;
    r.depth = d;
    r.err   = jts_pkg::E_NONE;
    nd      = d;
    unique case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA: begin
      end
      CH_LBRACK, CH_LBRACE: begin
        if (d >= LIMIT) begin
          r.cnt  = 2'd1;
          r.a    = jts_pkg::mk_item(jts_pkg::K_ERROR, 8'd0, d, jts_pkg::E_DEPTH);
          r.mode = M_ERR;
          r.err  = jts_pkg::E_DEPTH;
        end else begin
          // The depth is at least one afterwards, so the document goes on.
          nd      = d + 8'd1;
          r.depth = nd;
          r.cnt   = 2'd1;
          r.a     = jts_pkg::mk_item((c == CH_LBRACK) ? jts_pkg::K_BEGIN_ARR
                                                      : jts_pkg::K_BEGIN_OBJ,
                                     8'd0, nd, jts_pkg::E_NONE);
        end
      end
      CH_RBRACK, CH_RBRACE: begin
        if (d == 8'd0) begin
          r.cnt  = 2'd1;
          r.a    = jts_pkg::mk_item(jts_pkg::K_ERROR, 8'd0, d, jts_pkg::E_DEPTH);
          r.mode = M_ERR;
          r.err  = jts_pkg::E_DEPTH;
        end else begin
          nd      = d - 8'd1;
          r.depth = nd;
          r.cnt   = 2'd1;
          r.a     = jts_pkg::mk_item((c == CH_RBRACK) ? jts_pkg::K_END_ARR
                                                      : jts_pkg::K_END_OBJ,
                                     8'd0, nd, jts_pkg::E_NONE);
          if (nd == 8'd0) begin
            r.cnt  = 2'd2;
            r.b    = jts_pkg::mk_item(jts_pkg::K_DOC_END, 8'd0, nd, jts_pkg::E_NONE);
            r.mode = M_DONE;
          end
        end
      end
      CH_QUOTE: begin
        r.mode = M_STR;
      end
      default: begin
        if ((c == CH_MINUS) || is_digit(c)) begin
          r.cnt  = 2'd1;
          r.a    = jts_pkg::mk_item(jts_pkg::K_NUM_BYTE, c, d, jts_pkg::E_NONE);
          r.mode = M_NUM;
        end else begin
          r.cnt  = 2'd1;
          r.a    = jts_pkg::mk_item(jts_pkg::K_ERROR, 8'd0, d, jts_pkg::E_BAD_BYTE);
          r.mode = M_ERR;
          r.err  = jts_pkg::E_BAD_BYTE;
        end
      end
    endcase
    return r;
  endfunction

  mode_t          mode_r, mode_nxt, mode_cur;
  logic [7:0]     depth_r, depth_nxt, depth_cur;
  logic [15:0]    acc_r, acc_nxt, acc_cur;
  logic [1:0]     hcnt_r, hcnt_nxt, hcnt_cur;
  jts_pkg::err_t  err_r, err_nxt, err_cur;

  idle_t          idl;
  logic           hex_ok;
  logic [3:0]     hex_val;
  logic [15:0]    code;
  logic           is_ws_after;
  logic           is_num;
  logic [7:0]     esc_byte;

  // Restart clears the scan state in front of the current byte.
  always_comb begin
    mode_cur  = restart ? M_IDLE : mode_r;
    depth_cur = restart ? 8'd0 : depth_r;
    acc_cur   = restart ? 16'd0 : acc_r;
    hcnt_cur  = restart ? 2'd0 : hcnt_r;
    err_cur   = restart ? jts_pkg::E_NONE : err_r;
  end

  // Byte classes.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (is_digit(text_byte)) begin
      hex_val = 4'(text_byte - 8'h30);
    end else if ((text_byte >= 8'h41) && (text_byte <= 8'h46)) begin
      hex_val = 4'(text_byte - 8'h37);
    end else if ((text_byte >= 8'h61) && (text_byte <= 8'h66)) begin
      hex_val = 4'(text_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
    code        = {acc_cur[11:0], hex_val};
    is_ws_after = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    is_num      = is_digit(text_byte) || (text_byte == CH_PLUS) || (text_byte == CH_MINUS) ||
                  (text_byte == CH_LE) || (text_byte == CH_UE) || (text_byte == CH_DOT);
    unique case (text_byte)
      CH_LB:     esc_byte = 8'h08;
      CH_LF_ESC: esc_byte = 8'h0C;
      CH_LN:     esc_byte = 8'h0A;
      CH_LR:     esc_byte = 8'h0D;
      CH_LT:     esc_byte = 8'h09;
      default:   esc_byte = text_byte;
    endcase
    idl = run_idle(text_byte, depth_cur);
  end

  // Result bundle and next scan state for the current byte.
  always_comb begin
    bundle    = '0;
    mode_nxt  = mode_cur;
    depth_nxt = depth_cur;
    acc_nxt   = acc_cur;
    hcnt_nxt  = hcnt_cur;
    err_nxt   = err_cur;
    unique case (mode_cur)
      M_IDLE: begin
        bundle.cnt      = idl.cnt;
        bundle.items[0] = idl.a;
        bundle.items[1] = idl.b;
        mode_nxt        = idl.mode;
        depth_nxt       = idl.depth;
        err_nxt         = (idl.mode == M_ERR) ? idl.err : err_cur;
      end
      M_STR: begin
        if (text_byte == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else if (text_byte == CH_QUOTE) begin
          mode_nxt = M_AFTER;
        end else begin
          bundle.cnt      = 2'd1;
          bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE, text_byte, depth_cur,
                                             jts_pkg::E_NONE);
        end
      end
      M_ESC: begin
        if (text_byte == CH_LU) begin
          acc_nxt  = 16'd0;
          hcnt_nxt = 2'd0;
          mode_nxt = M_HEX;
        end else begin
          mode_nxt        = M_STR;
          bundle.cnt      = 2'd1;
          bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE, esc_byte, depth_cur,
                                             jts_pkg::E_NONE);
        end
      end
      M_HEX: begin
        if (!hex_ok) begin
          bundle.cnt      = 2'd1;
          bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_ERROR, 8'd0, depth_cur,
                                             jts_pkg::E_BAD_HEX);
          mode_nxt        = M_ERR;
          err_nxt         = jts_pkg::E_BAD_HEX;
        end else begin
          acc_nxt = code;
          if (hcnt_cur == 2'd3) begin
            hcnt_nxt = 2'd0;
            mode_nxt = M_STR;
            // UTF-8 encoding of the code point; a zero code gives nothing.
            priority if (code == 16'd0) begin
              bundle.cnt = 2'd0;
            end else if (code[15:7] == 9'd0) begin
              bundle.cnt      = 2'd1;
              bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE, code[7:0],
                                                 depth_cur, jts_pkg::E_NONE);
            end else if (code[15:11] == 5'd0) begin
              bundle.cnt      = 2'd2;
              bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE,
                                                 {3'b110, code[10:6]},
                                                 depth_cur, jts_pkg::E_NONE);
              bundle.items[1] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE,
                                                 {2'b10, code[5:0]},
                                                 depth_cur, jts_pkg::E_NONE);
            end else begin
              bundle.cnt      = 2'd3;
              bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE,
                                                 {4'b1110, code[15:12]},
                                                 depth_cur, jts_pkg::E_NONE);
              bundle.items[1] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE,
                                                 {2'b10, code[11:6]},
                                                 depth_cur, jts_pkg::E_NONE);
              bundle.items[2] = jts_pkg::mk_item(jts_pkg::K_STR_BYTE,
                                                 {2'b10, code[5:0]},
                                                 depth_cur, jts_pkg::E_NONE);
            end
          end else begin
            hcnt_nxt = hcnt_cur + 2'd1;
          end
        end
      end
      M_AFTER, M_NUM: begin
        if ((mode_cur == M_AFTER) && is_ws_after) begin
          mode_nxt = M_AFTER;
        end else if ((mode_cur == M_NUM) && is_num) begin
          bundle.cnt      = 2'd1;
          bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_NUM_BYTE, text_byte, depth_cur,
                                             jts_pkg::E_NONE);
        end else begin
          // The byte closes the token; at depth zero it also ends the document.
          if (mode_cur == M_NUM) begin
            bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_NUM_END, 8'd0, depth_cur,
                                               jts_pkg::E_NONE);
          end else if (text_byte == CH_COLON) begin
            bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_KEY_END, 8'd0, depth_cur,
                                               jts_pkg::E_NONE);
          end else begin
            bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_STR_END, 8'd0, depth_cur,
                                               jts_pkg::E_NONE);
          end
          if (depth_cur == 8'd0) begin
            bundle.cnt      = 2'd2;
            bundle.items[1] = jts_pkg::mk_item(jts_pkg::K_DOC_END, 8'd0, depth_cur,
                                               jts_pkg::E_NONE);
            mode_nxt        = M_DONE;
          end else if ((mode_cur == M_AFTER) && (text_byte == CH_COLON)) begin
            bundle.cnt = 2'd1;
            mode_nxt   = M_IDLE;
          end else begin
            // The closing byte is then scanned as a byte between tokens.
            bundle.cnt      = 2'd1 + idl.cnt;
            bundle.items[1] = idl.a;
            bundle.items[2] = idl.b;
            mode_nxt        = idl.mode;
            depth_nxt       = idl.depth;
            err_nxt         = (idl.mode == M_ERR) ? idl.err : err_cur;
          end
        end
      end
      M_DONE: begin
        bundle.cnt = 2'd0;
      end
      M_ERR: begin
        bundle.cnt      = 2'd1;
        bundle.items[0] = jts_pkg::mk_item(jts_pkg::K_ERROR, 8'd0, depth_cur, err_cur);
      end
      default: begin
        bundle.cnt = 2'd0;
      end
    endcase
  end

  assign push = accept && (bundle.cnt != 2'd0);

  // Scan state advances with every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      depth_r <= 8'd0;
      acc_r   <= 16'd0;
      hcnt_r  <= 2'd0;
      err_r   <= jts_pkg::E_NONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      acc_r   <= acc_nxt;
      hcnt_r  <= hcnt_nxt;
      err_r   <= err_nxt;
    end
  end

  `JTS_ASSERT(a_depth_limit, depth_r <= LIMIT, "nesting depth above its limit")
  `JTS_ASSERT_IMPL(a_err_code, mode_r == M_ERR, err_r != jts_pkg::E_NONE,
                   "error mode without an error code")

endmodule

/* sv/jts_fifo.sv */
// ----------------------------------------------------------------------------
// jts_fifo
// Short queue of result bundles between the scanner front and the output side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jts_fifo #(
  parameter int unsigned DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jts_pkg::bundle_t din,
  input  logic             pop,
  output jts_pkg::bundle_t dout,
  output logic             not_full,
  output logic             not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jts_pkg::bundle_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = (count_r != CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `JTS_ASSERT(a_fill_range, count_r <= CW'(DEPTH), "queue fill beyond its depth")
  `JTS_ASSERT_IMPL(a_no_overflow, push, not_full, "bundle pushed into a full queue")

endmodule

/* sv/jts_back.sv */
// ----------------------------------------------------------------------------
// jts_back
// Output side: walks the items of the head bundle, one per cycle unless
// stalled, into a registered output stage, marking each byte's last item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jts_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jts_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output jts_pkg::item_t   out_item,
  output logic             out_last
);

  logic            out_valid_r;
  logic [1:0]      idx_r;
  jts_pkg::item_t  item_r;
  logic            last_r;
  logic            load;
  logic            is_last;

  // With a bundle queued, the output register loads if empty or draining.
  assign load    = head_valid && (!out_valid_r || out_ready);
  assign is_last = (idx_r == (head.cnt - 2'd1));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= head.items[idx_r];
      last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = item_r;
  assign out_last  = last_r;

  `JTS_ASSERT_IMPL(a_head_nonempty, head_valid, head.cnt != 2'd0,
                   "empty bundle at the queue head")
  `JTS_ASSERT_IMPL(a_err_only_on_error, out_valid_r && (item_r.kind != jts_pkg::K_ERROR),
                   item_r.err == jts_pkg::E_NONE, "error code on a non-error item")

endmodule
